FILE: rtl/pdf_pkg.sv
// Package with the shared types and constants of the packet deframer.
package pdf_pkg;

	// Frame delimiters and special characters.
	localparam logic [7:0] TOKEN_START = 8'h01;
	localparam logic [7:0] TOKEN_END   = 8'hFE;
	localparam logic [7:0] CODE_SPACE  = 8'd32;
	localparam logic [7:0] CODE_ESC    = 8'd27;
	localparam logic [7:0] CODE_CR     = 8'd13;
	localparam logic [7:0] CODE_LF     = 8'd10;

	// Highest line index before a further character discards the line.
	localparam logic [7:0] LINE_LAST_INDEX = 8'd255;

	// Configuration register reset values.
	localparam logic [7:0]  OWN_ID_RESET      = 8'd1;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd25000;
	localparam logic [7:0]  ESC_PRESSES_RESET = 8'd3;

	// Configuration register indexes (word address).
	localparam int unsigned PADDR_W = 4;
	typedef enum logic [1:0] {
		REG_OWN_ID      = 2'd0,
		REG_TIMEOUT     = 2'd1,
		REG_ESC_PRESSES = 2'd2
	} reg_idx_t;

	// Kind of a result item.
	typedef enum logic [3:0] {
		KIND_PAYLOAD  = 4'd0,
		KIND_ACCEPT   = 4'd1,
		KIND_REJECT   = 4'd2,
		KIND_TIMEOUT  = 4'd3,
		KIND_TERM_CHR = 4'd4,
		KIND_LINE     = 4'd5,
		KIND_OVERFLOW = 4'd6,
		KIND_ENTER    = 4'd7,
		KIND_EXIT     = 4'd8
	} kind_t;

	// Input function code.
	typedef enum logic {
		FUNC_BYTE = 1'b0,
		FUNC_TICK = 1'b1
	} func_t;

	// Frame parser steps, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LEN  = 7'b0000010,
		ST_ID   = 7'b0000100,
		ST_CMD  = 7'b0001000,
		ST_PAY  = 7'b0010000,
		ST_CHK  = 7'b0100000,
		ST_END  = 7'b1000000
	} step_t;

endpackage

FILE: rtl/pdf_in_if.sv
// Input channel carrying received bytes and timer ticks.
interface pdf_in_if;
	logic                valid;
	logic                ready;
	pdf_pkg::func_t      func;
	logic [7:0]          rx_byte;

	modport source (output valid, func, rx_byte, input ready);
	modport sink   (input valid, func, rx_byte, output ready);
endinterface

FILE: rtl/pdf_out_if.sv
// Output channel carrying deframer and terminal events.
interface pdf_out_if;
	logic                valid;
	logic                ready;
	pdf_pkg::kind_t      kind;
	logic [7:0]          value;
	logic [7:0]          position;
	logic [7:0]          command;
	logic [7:0]          length;

	modport source (output valid, kind, value, position, command, length, input ready);
	modport sink   (input valid, kind, value, position, command, length, output ready);
endinterface

FILE: rtl/packet_deframer_with_terminal_mode.sv
// Packet deframer with timeout and terminal mode, with its APB register port.
// An accepted item moves from the input register into the output register, which holds its result, if any.
// Throughput: one item per cycle; the input register only stalls when a result
// is pending and the output register holds an item that has not been taken.
// Reset clears the frame parser, timer and terminal state and loads the register
// defaults (device id 1, timeout 25000 ticks, three spaces to enter terminal mode).
module packet_deframer_with_terminal_mode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pdf_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	pdf_in_if.sink                       byte_ch,
	pdf_out_if.source                    event_ch
);
	import pdf_pkg::*;

	// Architectural state of the parser.
	typedef struct packed {
		step_t       step;
		logic        good;
		logic [7:0]  flen;
		logic [7:0]  sum;
		logic [7:0]  cmd;
		logic [7:0]  pidx;
		logic        tmr_run;
		logic [15:0] tmr_cnt;
		logic        term;
		logic [7:0]  spaces;
		logic        line_act;
		logic [7:0]  line_idx;
	} pstate_t;

	// One result item.
	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  value;
		logic [7:0]  position;
		logic [7:0]  command;
		logic [7:0]  length;
	} result_t;

	// Parser state after reset: waiting for a start byte, everything else clear.
	localparam pstate_t PSTATE_RESET = '{
		step:     ST_IDLE,
		good:     1'b0,
		flen:     8'd0,
		sum:      8'd0,
		cmd:      8'd0,
		pidx:     8'd0,
		tmr_run:  1'b0,
		tmr_cnt:  16'd0,
		term:     1'b0,
		spaces:   8'd0,
		line_act: 1'b0,
		line_idx: 8'd0
	};

	logic [7:0]  own_id_q;
	logic [15:0] timeout_q;
	logic [7:0]  esc_presses_q;

	logic        valid_s1;
	func_t       func_s1;
	logic [7:0]  byte_s1;

	pstate_t     st_q;
	pstate_t     st_nxt;
	result_t     res;
	result_t     out_q;

	logic        advance;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;
	logic [15:0] tmr_inc;
	logic [7:0]  spaces_inc;
	logic [7:0]  sum_add;
	logic [7:0]  pidx_inc;

	// Register port: writes in the access phase, reads by word index.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q      <= OWN_ID_RESET;
			timeout_q     <= TIMEOUT_RESET;
			esc_presses_q <= ESC_PRESSES_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_OWN_ID:      own_id_q      <= pwdata[7:0];
				REG_TIMEOUT:     timeout_q     <= pwdata[15:0];
				REG_ESC_PRESSES: esc_presses_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_OWN_ID:      prdata = {24'd0, own_id_q};
			REG_TIMEOUT:     prdata = {16'd0, timeout_q};
			REG_ESC_PRESSES: prdata = {24'd0, esc_presses_q};
			default:         prdata = 32'd0;
		endcase
	end

	// The input register moves on when there is no result or room for one.
	assign advance       = valid_s1 && (!res.valid || !out_q.valid || event_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			func_s1 <= byte_ch.func;
			byte_s1 <= byte_ch.rx_byte;
		end
	end

	// Helper arithmetic shared by the branches below.
	assign tmr_inc    = (st_q.tmr_cnt == 16'hFFFF) ? st_q.tmr_cnt : st_q.tmr_cnt + 16'd1;
	assign spaces_inc = (st_q.spaces == 8'hFF) ? st_q.spaces : st_q.spaces + 8'd1;
	assign sum_add    = st_q.sum + byte_s1;
	assign pidx_inc   = st_q.pidx + 8'd1;

	// Next state and result for the item in the input register.
	always_comb begin
		st_nxt = st_q;
		res    = '0;
		if (func_s1 == FUNC_TICK) begin
			// Timer tick: only counts while a frame is in progress.
			if (st_q.tmr_run) begin
				if (tmr_inc >= timeout_q) begin
					st_nxt.tmr_run = 1'b0;
					st_nxt.tmr_cnt = '0;
					st_nxt.step    = ST_IDLE;
					st_nxt.pidx    = '0;
					res.valid      = 1'b1;
					res.kind       = KIND_TIMEOUT;
				end else begin
					st_nxt.tmr_cnt = tmr_inc;
				end
			end
		end else if (st_q.term) begin
			// Terminal mode: characters, line completion, overflow, exit.
			st_nxt.tmr_run = 1'b0;
			res.valid      = 1'b1;
			res.value      = byte_s1;
			if (byte_s1 == CODE_ESC) begin
				st_nxt.term   = 1'b0;
				st_nxt.spaces = '0;
				res.kind      = KIND_EXIT;
				res.value     = '0;
			end else if (st_q.line_act) begin
				if (byte_s1 == CODE_CR || byte_s1 == CODE_LF) begin
					st_nxt.line_act = 1'b0;
					st_nxt.line_idx = '0;
					res.kind        = KIND_LINE;
					res.length      = st_q.line_idx;
				end else if (st_q.line_idx >= LINE_LAST_INDEX) begin
					st_nxt.line_act = 1'b0;
					st_nxt.line_idx = '0;
					res.kind        = KIND_OVERFLOW;
					res.position    = st_q.line_idx;
				end else begin
					st_nxt.line_idx = st_q.line_idx + 8'd1;
					res.kind        = KIND_TERM_CHR;
					res.position    = st_q.line_idx;
				end
			end else begin
				st_nxt.line_act = 1'b1;
				if (st_q.line_idx < LINE_LAST_INDEX) begin
					st_nxt.line_idx = st_q.line_idx + 8'd1;
				end
				res.kind     = KIND_TERM_CHR;
				res.position = st_q.line_idx;
			end
		end else begin
			// Packet mode: frame parser.
			st_nxt.tmr_cnt = '0;
			unique case (st_q.step)
				ST_IDLE: begin
					st_nxt.tmr_cnt = st_q.tmr_cnt;
					if (byte_s1 == TOKEN_START) begin
						st_nxt.tmr_cnt = '0;
						st_nxt.tmr_run = 1'b1;
						st_nxt.good    = 1'b1;
						st_nxt.step    = ST_LEN;
					end else begin
						st_nxt.tmr_run = 1'b0;
						if (byte_s1 == CODE_SPACE) begin
							st_nxt.spaces = spaces_inc;
							if (spaces_inc >= esc_presses_q) begin
								st_nxt.term = 1'b1;
								res.valid   = 1'b1;
								res.kind    = KIND_ENTER;
							end
						end
					end
				end
				ST_LEN: begin
					st_nxt.flen = byte_s1;
					st_nxt.sum  = byte_s1;
					st_nxt.step = ST_ID;
				end
				ST_ID: begin
					if (byte_s1 == own_id_q) begin
						st_nxt.sum = sum_add;
					end else begin
						st_nxt.good = 1'b0;
					end
					st_nxt.step = ST_CMD;
				end
				ST_CMD: begin
					if (st_q.good) begin
						st_nxt.cmd = byte_s1;
						st_nxt.sum = sum_add;
					end
					st_nxt.step = (st_q.flen != 8'd0) ? ST_PAY : ST_CHK;
				end
				ST_PAY: begin
					if (st_q.good) begin
						st_nxt.sum   = sum_add;
						res.valid    = 1'b1;
						res.kind     = KIND_PAYLOAD;
						res.value    = byte_s1;
						res.position = st_q.pidx;
						res.command  = st_q.cmd;
						res.length   = st_q.flen;
					end
					st_nxt.pidx = pidx_inc;
					if (pidx_inc >= st_q.flen) begin
						st_nxt.step = ST_CHK;
					end
				end
				ST_CHK: begin
					if (byte_s1 != ~st_q.sum) begin
						st_nxt.good = 1'b0;
					end
					st_nxt.step = ST_END;
				end
				ST_END: begin
					st_nxt.tmr_cnt = st_q.tmr_cnt;
					st_nxt.tmr_run = 1'b0;
					st_nxt.step    = ST_IDLE;
					st_nxt.pidx    = '0;
					res.valid      = 1'b1;
					res.length     = st_q.flen;
					if (st_q.good && byte_s1 == TOKEN_END) begin
						res.kind    = KIND_ACCEPT;
						res.command = st_q.cmd;
					end else begin
						res.kind = KIND_REJECT;
					end
				end
				default: begin
					st_nxt.tmr_cnt = st_q.tmr_cnt;
					st_nxt.step    = ST_IDLE;
					st_nxt.pidx    = '0;
				end
			endcase
		end
	end

	// Parser state is committed when the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PSTATE_RESET;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance && res.valid) begin
			out_q <= res;
		end else if (event_ch.ready) begin
			out_q.valid <= 1'b0;
		end
	end

	assign event_ch.valid    = out_q.valid;
	assign event_ch.kind     = out_q.kind;
	assign event_ch.value    = out_q.value;
	assign event_ch.position = out_q.position;
	assign event_ch.command  = out_q.command;
	assign event_ch.length   = out_q.length;

	// The timer never runs while the terminal is active.
	a_term_no_timer: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.term |-> !st_q.tmr_run)
		else $error("timer running in terminal mode");

	// The payload index is cleared whenever the parser waits for a start byte.
	a_idle_pidx: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.step == ST_IDLE) |-> (st_q.pidx == 8'd0))
		else $error("payload index not cleared at idle");

	// The line index never passes its last value.
	a_line_idx: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.line_idx <= LINE_LAST_INDEX)
		else $error("line index beyond last index");

	// Entering terminal mode always presents an enter item.
	a_enter_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.term) |-> (out_q.valid && out_q.kind == KIND_ENTER))
		else $error("terminal entered without enter item");

endmodule
